// ===== src/byte_ring_buffer_with_offset_insert_defines.svh =====
// assertion macros for the byte ring buffer
// used by the top level only; expects clk and arst_n in scope
`ifndef BYTE_RING_BUFFER_WITH_OFFSET_INSERT_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_OFFSET_INSERT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/brb_pkg.sv =====
// shared types, codes and helpers for the byte ring buffer
// no dependencies
`default_nettype none

package brb_pkg;

	// field widths fixed by the interface
	localparam int CW = 13;
	localparam int BW = 7;
	localparam int CAP_RESET = 4096;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// item kinds
	localparam logic [2:0] KIND_PUSH    = 3'd0;
	localparam logic [2:0] KIND_INSERT  = 3'd1;
	localparam logic [2:0] KIND_ADVANCE = 3'd2;
	localparam logic [2:0] KIND_POP     = 3'd3;
	localparam logic [2:0] KIND_PEEK    = 3'd4;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SPACE  = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_BURST     = 3'd4;

	typedef struct packed {
		logic [2:0]    kind;
		logic [7:0]    data_byte;
		logic [CW-1:0] count;
		logic [CW-1:0] offset;
		logic          first;
		logic          want_bytes;
	} in_item_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [7:0]    out_byte;
		logic          byte_valid;
		logic          last;
		logic [CW-1:0] fill_level;
		logic [CW-1:0] free_bytes;
	} out_item_t;

	// what the back end does with a command
	typedef enum logic [1:0] {
		OP_NOTE,
		OP_WRITE,
		OP_READ
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t       op;
		logic [2:0]    status;
		logic [CW-1:0] addr;
		logic [7:0]    data;
		logic [BW-1:0] n;
		logic [CW-1:0] fill;
		logic [CW-1:0] free;
	} cmd_t;

	// front state visible to the rest of the block
	typedef struct packed {
		logic [CW-1:0] capacity;
		logic [CW-1:0] held;
	} front_stat_t;

	// ring pointer plus amount, wrapped once at capacity
	function automatic logic [CW-1:0] wrap_add(input logic [CW-1:0] ptr,
			input logic [CW-1:0] amt, input logic [CW-1:0] cap);
		logic [CW:0] sum;
		sum = {1'b0, ptr} + {1'b0, amt};
		if (sum >= {1'b0, cap}) begin
			sum = sum - {1'b0, cap};
		end
		return sum[CW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/brb_front.sv =====
// front end: takes items, checks them against the ring state, updates pointers
// and hands one command per item to the queue; depends on brb_pkg
`default_nettype none

module brb_front #(
	parameter int DEPTH = 4096,
	parameter int MAX_BURST = 64
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           item_valid,
	output logic                          item_stall,
	input  brb_pkg::in_item_t             item,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [brb_pkg::CW-1:0]        cfg_data,
	output logic                          cmd_valid,
	output brb_pkg::cmd_t                 cmd,
	input  wire                           cmd_full,
	output brb_pkg::front_stat_t          stat
);

	localparam int CW = brb_pkg::CW;
	localparam int CAP_LIM = (1 << CW) - 1;
	localparam int CAP_MAX = (DEPTH < CAP_LIM) ? DEPTH : CAP_LIM;
	localparam int CAP_RST = (DEPTH < brb_pkg::CAP_RESET) ? DEPTH : brb_pkg::CAP_RESET;
	localparam int PW = $clog2(CAP_MAX);
	localparam logic [CW-1:0] CAP_MAX_C = CW'(CAP_MAX);
	localparam logic [CW-1:0] CAP_RST_C = CW'(CAP_RST);
	localparam logic [CW-1:0] BURST_C = CW'(MAX_BURST);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic                s1_valid_q;
	brb_pkg::in_item_t   item_s1;
	logic [CW-1:0]       cap_q;
	logic [PW-1:0]       head_q;
	logic [PW-1:0]       tail_q;
	logic [CW-1:0]       held_q;
	logic [PW-1:0]       rwp_q;
	logic                rej_q;

	logic [PW-1:0]       nxt_head;
	logic [PW-1:0]       nxt_tail;
	logic [CW-1:0]       nxt_held;
	logic [PW-1:0]       nxt_rwp;
	logic                nxt_rej;
	brb_pkg::cmd_t       c;

	logic [CW-1:0]       free_c;
	logic [CW:0]         ins_need;
	logic                push_rej;
	logic                ins_rej;
	logic [CW-1:0]       ins_wp;
	logic [CW-1:0]       peek_avail;
	logic [CW-1:0]       peek_n;
	logic [CW-1:0]       cfg_cap;
	logic                do_step;
	logic                cfg_wr;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign do_step    = s1_valid_q && !cmd_full;
	assign item_stall = s1_valid_q && cmd_full;
	assign cmd_valid  = s1_valid_q;
	assign cmd        = c;
	assign stat.capacity = cap_q;
	assign stat.held     = held_q;

	// clamp the written capacity into 1..store depth
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cap = ONE_C;
		end else if (cfg_data > CAP_MAX_C) begin
			cfg_cap = CAP_MAX_C;
		end else begin
			cfg_cap = cfg_data;
		end
	end

	// checks used by the item kinds, some shared by several
	always_comb begin
		free_c     = cap_q - held_q;
		ins_need   = {1'b0, item_s1.offset} + {1'b0, item_s1.count};
		push_rej   = item_s1.first ? (item_s1.count > free_c) : rej_q;
		ins_rej    = item_s1.first ? (ins_need > {1'b0, free_c}) : rej_q;
		ins_wp     = item_s1.first ? brb_pkg::wrap_add(CW'(tail_q), item_s1.offset, cap_q)
			: CW'(rwp_q);
		peek_avail = (item_s1.offset < held_q) ? (held_q - item_s1.offset) : '0;
		peek_n     = (item_s1.count < peek_avail) ? item_s1.count : peek_avail;
	end

	// classify the item and work out the next ring state
	always_comb begin
		nxt_head = head_q;
		nxt_tail = tail_q;
		nxt_held = held_q;
		nxt_rwp  = rwp_q;
		nxt_rej  = rej_q;
		c        = '0;
		c.op     = brb_pkg::OP_NOTE;
		c.status = brb_pkg::ST_OK;
		c.data   = item_s1.data_byte;
		unique case (item_s1.kind)
			brb_pkg::KIND_PUSH: begin
				nxt_rej = push_rej;
				if (push_rej || held_q >= cap_q) begin
					c.status = brb_pkg::ST_NO_SPACE;
				end else begin
					c.op     = brb_pkg::OP_WRITE;
					c.addr   = CW'(tail_q);
					nxt_tail = PW'(brb_pkg::wrap_add(CW'(tail_q), ONE_C, cap_q));
					nxt_held = held_q + ONE_C;
				end
			end
			brb_pkg::KIND_INSERT: begin
				nxt_rej = ins_rej;
				if (ins_rej) begin
					c.status = brb_pkg::ST_NO_SPACE;
				end else begin
					c.op    = brb_pkg::OP_WRITE;
					c.addr  = ins_wp;
					nxt_rwp = PW'(brb_pkg::wrap_add(ins_wp, ONE_C, cap_q));
				end
			end
			brb_pkg::KIND_ADVANCE: begin
				if (item_s1.count > free_c) begin
					c.status = brb_pkg::ST_NO_SPACE;
				end else begin
					nxt_tail = PW'(brb_pkg::wrap_add(CW'(tail_q), item_s1.count, cap_q));
					nxt_held = held_q + item_s1.count;
				end
			end
			brb_pkg::KIND_POP: begin
				priority if (held_q == '0) begin
					c.status = brb_pkg::ST_EMPTY;
				end else if (item_s1.count > held_q) begin
					c.status = brb_pkg::ST_UNDERFLOW;
				end else if (item_s1.want_bytes && item_s1.count > BURST_C) begin
					c.status = brb_pkg::ST_BURST;
				end else begin
					nxt_head = PW'(brb_pkg::wrap_add(CW'(head_q), item_s1.count, cap_q));
					nxt_held = held_q - item_s1.count;
					if (item_s1.want_bytes && item_s1.count != '0) begin
						c.op   = brb_pkg::OP_READ;
						c.addr = CW'(head_q);
						c.n    = item_s1.count[brb_pkg::BW-1:0];
					end
				end
			end
			brb_pkg::KIND_PEEK: begin
				if (item_s1.count > BURST_C) begin
					c.status = brb_pkg::ST_BURST;
				end else if (peek_n != '0) begin
					c.op   = brb_pkg::OP_READ;
					c.addr = brb_pkg::wrap_add(CW'(head_q), item_s1.offset, cap_q);
					c.n    = peek_n[brb_pkg::BW-1:0];
				end
			end
			default: begin
				c.status = brb_pkg::ST_OK;
			end
		endcase
		c.fill = nxt_held;
		c.free = cap_q - nxt_held;
	end

	// input register and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			cap_q      <= CAP_RST_C;
			head_q     <= '0;
			tail_q     <= '0;
			held_q     <= '0;
			rwp_q      <= '0;
			rej_q      <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				s1_valid_q <= 1'b1;
			end else if (do_step) begin
				s1_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				cap_q  <= cfg_cap;
				head_q <= '0;
				tail_q <= '0;
				held_q <= '0;
				rwp_q  <= '0;
				rej_q  <= 1'b0;
			end else if (do_step) begin
				head_q <= nxt_head;
				tail_q <= nxt_tail;
				held_q <= nxt_held;
				rwp_q  <= nxt_rwp;
				rej_q  <= nxt_rej;
			end
		end
	end

	// item payload on transfer
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ===== src/brb_queue.sv =====
// short command queue between the front and back ends
// depends on brb_pkg
`default_nettype none

module brb_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  brb_pkg::cmd_t  push_cmd,
	output logic           full,
	output logic           valid,
	output brb_pkg::cmd_t  head_cmd,
	input  wire            pop
);

	localparam int QAW = brb_pkg::QAW;
	localparam logic [QAW:0] QDEPTH_C = (QAW + 1)'(brb_pkg::QDEPTH);

	brb_pkg::cmd_t   slots [brb_pkg::QDEPTH];
	logic [QAW-1:0]  wptr_q;
	logic [QAW-1:0]  rptr_q;
	logic [QAW:0]    cnt_q;

	assign full     = (cnt_q == QDEPTH_C);
	assign valid    = (cnt_q != '0);
	assign head_cmd = slots[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== src/brb_back.sv =====
// back end: owns the byte store, performs writes and read bursts, and
// drives the registered result port; depends on brb_pkg
`default_nettype none

module brb_back #(
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmd_valid,
	input  brb_pkg::cmd_t           cmd,
	output logic                    cmd_take,
	input  wire  [brb_pkg::CW-1:0]  capacity,
	output logic                    result_valid,
	input  wire                     result_stall,
	output brb_pkg::out_item_t      result
);

	localparam int CW = brb_pkg::CW;
	localparam int BW = brb_pkg::BW;
	localparam int CAP_LIM = (1 << CW) - 1;
	localparam int CAP_MAX = (DEPTH < CAP_LIM) ? DEPTH : CAP_LIM;
	localparam int PW = $clog2(CAP_MAX);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [BW-1:0] ONE_N = BW'(1);

	logic [7:0]     mem [CAP_MAX];

	logic           burst_act_q;
	logic [PW-1:0]  burst_addr_q;
	logic [BW-1:0]  burst_rem_q;
	logic [CW-1:0]  burst_fill_q;
	logic [CW-1:0]  burst_free_q;

	logic           res_valid_q;
	logic [2:0]     res_status_q;
	logic           res_bv_q;
	logic           res_last_q;
	logic [CW-1:0]  res_fill_q;
	logic [CW-1:0]  res_free_q;
	logic [7:0]     rd_q;

	logic           slot_free;
	logic           issue;
	logic           issue_write;
	logic           issue_read;
	logic           cmd_is_read;
	logic [PW-1:0]  cmd_addr;
	logic [PW-1:0]  rd_addr;
	logic [PW-1:0]  next_addr;

	// issue one result per cycle while the output slot can take it
	assign slot_free   = !res_valid_q || !result_stall;
	assign cmd_take    = slot_free && !burst_act_q && cmd_valid;
	assign issue       = cmd_take || (slot_free && burst_act_q);
	assign cmd_is_read = (cmd.op == brb_pkg::OP_READ);
	assign cmd_addr    = cmd.addr[PW-1:0];
	assign issue_write = cmd_take && (cmd.op == brb_pkg::OP_WRITE);
	assign issue_read  = burst_act_q ? slot_free : (cmd_take && cmd_is_read);
	assign rd_addr     = burst_act_q ? burst_addr_q : cmd_addr;
	assign next_addr   = PW'(brb_pkg::wrap_add(CW'(rd_addr), ONE_C, capacity));

	// result port
	assign result_valid      = res_valid_q;
	assign result.status     = res_status_q;
	assign result.out_byte   = res_bv_q ? rd_q : 8'd0;
	assign result.byte_valid = res_bv_q;
	assign result.last       = res_last_q;
	assign result.fill_level = res_fill_q;
	assign result.free_bytes = res_free_q;

	// byte store, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (issue_write) begin
			mem[cmd_addr] <= cmd.data;
		end
		if (issue_read) begin
			rd_q <= mem[rd_addr];
		end
	end

	// burst tracking and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_act_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				res_valid_q <= 1'b1;
			end else if (slot_free) begin
				res_valid_q <= 1'b0;
			end
			if (burst_act_q && slot_free && burst_rem_q == ONE_N) begin
				burst_act_q <= 1'b0;
			end else if (cmd_take && cmd_is_read && cmd.n != ONE_N) begin
				burst_act_q <= 1'b1;
			end
		end
	end

	// burst position and result fields
	always_ff @(posedge clk) begin
		if (burst_act_q && slot_free) begin
			burst_addr_q <= next_addr;
			burst_rem_q  <= burst_rem_q - ONE_N;
			res_status_q <= brb_pkg::ST_OK;
			res_bv_q     <= 1'b1;
			res_last_q   <= (burst_rem_q == ONE_N);
			res_fill_q   <= burst_fill_q;
			res_free_q   <= burst_free_q;
		end else if (cmd_take) begin
			burst_addr_q <= next_addr;
			burst_rem_q  <= cmd.n - ONE_N;
			burst_fill_q <= cmd.fill;
			burst_free_q <= cmd.free;
			res_status_q <= cmd.status;
			res_bv_q     <= cmd_is_read;
			res_last_q   <= !cmd_is_read || (cmd.n == ONE_N);
			res_fill_q   <= cmd.fill;
			res_free_q   <= cmd.free;
		end
	end

endmodule

`default_nettype wire

// ===== src/byte_ring_buffer_with_offset_insert.sv =====
// Byte ring buffer with offset insert, for stream reassembly. Push, insert,
// advance and every rejected or byteless operation give one result each.
// A pop or peek that returns n bytes (n up to MAX_BURST) gives n results, one
// per cycle while the result port is not stalled, paced by the single read port
// of the byte store in the back end. The front end keeps accepting items during
// a burst until the four-entry command queue fills. A capacity write empties
// the buffer and may only be issued while the block is idle.
// Depends on brb_pkg, brb_front, brb_queue, brb_back and the defines header.
`default_nettype none

`include "byte_ring_buffer_with_offset_insert_defines.svh"

module byte_ring_buffer_with_offset_insert #(
	parameter int DEPTH = 4096,
	parameter int MAX_BURST = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	output logic                      item_stall,
	input  brb_pkg::in_item_t         item,
	output logic                      result_valid,
	input  wire                       result_stall,
	output brb_pkg::out_item_t        result,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire  [brb_pkg::CW-1:0]    cfg_data
);

	logic                   q_push;
	brb_pkg::cmd_t          q_in;
	logic                   q_full;
	logic                   q_valid;
	brb_pkg::cmd_t          q_head;
	logic                   q_pop;
	brb_pkg::front_stat_t   stat;
	logic                   front_cmd_valid;

	// pushes happen whenever the front has an item and the queue has room
	assign q_push = front_cmd_valid && !q_full;

	// classification and ring state
	brb_front #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.cmd_valid  (front_cmd_valid),
		.cmd        (q_in),
		.cmd_full   (q_full),
		.stat       (stat)
	);

	// decoupling queue
	brb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.valid    (q_valid),
		.head_cmd (q_head),
		.pop      (q_pop)
	);

	// store access and result port
	brb_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (q_head),
		.cmd_take     (q_pop),
		.capacity     (stat.capacity),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// results report a consistent fill and free space
	`BRB_ASSERT_IMPL(a_fill_free, result_valid, (result.fill_level + result.free_bytes) == stat.capacity && result.fill_level <= stat.capacity, "fill and free do not add up to capacity")
	// a returned byte always comes with an ok status
	`BRB_ASSERT_IMPL(a_byte_ok, result_valid && result.byte_valid, result.status == brb_pkg::ST_OK, "byte returned with error status")
	// only bursts give more than one result per item
	`BRB_ASSERT_IMPL(a_note_last, result_valid && !result.byte_valid, result.last, "byteless result not marked last")
	// a capacity write empties the buffer
	`BRB_ASSERT_NEXT(a_cfg_empties, cfg_valid && cfg_ready, stat.held == '0, "capacity write left bytes held")

endmodule

`default_nettype wire
